### hw/rtl/dgp_pkg.sv
// Package with shared widths, types, register codes and the Bayer dither table.
package dgp_pkg;

    localparam int unsigned POS_W      = 13;
    localparam int unsigned STEP_W     = 8;
    localparam int unsigned FLOOR_W    = 21;
    localparam int unsigned BASE_W     = 8;
    localparam int unsigned SCALE_W    = 31;
    localparam int unsigned WORD_W     = BASE_W + SCALE_W;
    localparam int unsigned PART_W     = POS_W + 1 + STEP_W + 1;
    localparam int unsigned GRAD_W     = PART_W + 2;
    localparam int unsigned DITH_W     = 6;
    localparam int unsigned FRAC_BITS  = 23;
    localparam int unsigned DITH_SHIFT = FRAC_BITS - DITH_W;
    localparam int unsigned CHAN_N     = 4;
    localparam int unsigned APB_DW     = 64;
    localparam int unsigned APB_AW     = 6;
    localparam int unsigned MAX_DIM_DEF = 4096;
    localparam int unsigned POS_TOP    = (1 << POS_W) - 1;
    localparam logic [BASE_W-1:0] OPAQUE_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        REG_STEP_X   = 3'd0,
        REG_STEP_Y   = 3'd1,
        REG_FLOOR    = 3'd2,
        REG_ALPHA    = 3'd3,
        REG_CHAN0    = 3'd4,
        REG_CHAN1    = 3'd5,
        REG_CHAN2    = 3'd6,
        REG_CHAN3    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [STEP_W-1:0]         step_x;
        logic signed [STEP_W-1:0]         step_y;
        logic signed [FLOOR_W-1:0]        grad_floor;
        logic                             alpha_mode;
        logic [CHAN_N-1:0][BASE_W-1:0]    base;
        logic [CHAN_N-1:0][SCALE_W-1:0]   scale;
    } t_cfg;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    localparam logic [DITH_W-1:0] BAYER [64] = '{
        6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
        6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
        6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
        6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
        6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
        6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
        6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
        6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
    };

endpackage

### hw/rtl/dgp_if.sv
// Handshake interfaces for the pixel coordinate and pixel color channels.
interface dgp_pos_if;
    logic                      valid;
    logic                      ready;
    logic [dgp_pkg::POS_W-1:0] pos_x;
    logic [dgp_pkg::POS_W-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface dgp_pix_if;
    logic                       valid;
    logic                       ready;
    logic [dgp_pkg::BASE_W-1:0] byte0;
    logic [dgp_pkg::BASE_W-1:0] byte1;
    logic [dgp_pkg::BASE_W-1:0] byte2;
    logic [dgp_pkg::BASE_W-1:0] byte3;

    modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                    input ready);
    modport sink   (input valid, input byte0, input byte1, input byte2, input byte3,
                    output ready);
endinterface

### hw/rtl/dgp_regs.sv
// APB configuration register file of the gradient pixel source.
module dgp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dgp_pkg::APB_AW-1:0]  paddr,
    input  logic [dgp_pkg::APB_DW-1:0]  pwdata,
    output logic [dgp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output dgp_pkg::t_cfg               o_cfg
);
    import dgp_pkg::*;

    logic [STEP_W-1:0]                 r_step_x;
    logic [STEP_W-1:0]                 r_step_y;
    logic [FLOOR_W-1:0]                r_floor;
    logic                              r_alpha;
    logic [CHAN_N-1:0][WORD_W-1:0]     r_word;
    t_reg_idx                          idx;
    logic                              wr;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x <= '0;
            r_step_y <= '0;
            r_floor  <= '0;
            r_alpha  <= 1'b0;
            r_word   <= '0;
        end else if (wr) begin
            case (idx)
                REG_STEP_X: r_step_x  <= pwdata[STEP_W-1:0];
                REG_STEP_Y: r_step_y  <= pwdata[STEP_W-1:0];
                REG_FLOOR:  r_floor   <= pwdata[FLOOR_W-1:0];
                REG_ALPHA:  r_alpha   <= pwdata[0];
                REG_CHAN0:  r_word[0] <= pwdata[WORD_W-1:0];
                REG_CHAN1:  r_word[1] <= pwdata[WORD_W-1:0];
                REG_CHAN2:  r_word[2] <= pwdata[WORD_W-1:0];
                REG_CHAN3:  r_word[3] <= pwdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_STEP_X: prdata = APB_DW'(r_step_x);
            REG_STEP_Y: prdata = APB_DW'(r_step_y);
            REG_FLOOR:  prdata = APB_DW'(r_floor);
            REG_ALPHA:  prdata = APB_DW'(r_alpha);
            REG_CHAN0:  prdata = APB_DW'(r_word[0]);
            REG_CHAN1:  prdata = APB_DW'(r_word[1]);
            REG_CHAN2:  prdata = APB_DW'(r_word[2]);
            REG_CHAN3:  prdata = APB_DW'(r_word[3]);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.step_x     = $signed(r_step_x);
        o_cfg.step_y     = $signed(r_step_y);
        o_cfg.grad_floor = $signed(r_floor);
        o_cfg.alpha_mode = r_alpha;
        for (int c = 0; c < CHAN_N; c++) begin
            o_cfg.base[c]  = r_word[c][BASE_W-1:0];
            o_cfg.scale[c] = r_word[c][WORD_W-1:BASE_W];
        end
    end

endmodule

### hw/rtl/dgp_grad.sv
// Coordinate clamp, weighted products, gradient sum and dither lookup (stages 1 and 2).
module dgp_grad #(
    parameter int unsigned MAX_DIM = dgp_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  dgp_pkg::t_pipe_en                  i_en,
    input  dgp_pkg::t_cfg                      i_cfg,
    input  logic [dgp_pkg::POS_W-1:0]          i_pos_x,
    input  logic [dgp_pkg::POS_W-1:0]          i_pos_y,
    output logic signed [dgp_pkg::GRAD_W-1:0]  o_grad,
    output logic [dgp_pkg::DITH_W-1:0]         o_dith
);
    import dgp_pkg::*;

    localparam int unsigned LIM = (MAX_DIM > POS_TOP) ? POS_TOP : MAX_DIM;
    localparam logic [POS_W-1:0] LIM_C = POS_W'(LIM);

    logic [POS_W-1:0]          x_c;
    logic [POS_W-1:0]          y_c;
    logic signed [PART_W-1:0]  n_px;
    logic signed [PART_W-1:0]  n_py;
    logic signed [PART_W-1:0]  r_px;
    logic signed [PART_W-1:0]  r_py;
    logic [DITH_W-1:0]         r_dith1;
    logic signed [GRAD_W-1:0]  n_grad;
    logic signed [GRAD_W-1:0]  r_grad;
    logic [DITH_W-1:0]         r_dith2;

    always_comb begin
        x_c    = (i_pos_x > LIM_C) ? LIM_C : i_pos_x;
        y_c    = (i_pos_y > LIM_C) ? LIM_C : i_pos_y;
        n_px   = PART_W'($signed({1'b0, x_c})) * PART_W'(i_cfg.step_x);
        n_py   = PART_W'($signed({1'b0, y_c})) * PART_W'(i_cfg.step_y);
        n_grad = GRAD_W'(r_px) + GRAD_W'(r_py) - GRAD_W'(i_cfg.grad_floor);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_dith1 <= BAYER[{y_c[2:0], x_c[2:0]}];
        end
        if (i_en.s2) begin
            r_grad  <= n_grad;
            r_dith2 <= r_dith1;
        end
    end

    assign o_grad = r_grad;
    assign o_dith = r_dith2;

endmodule

### hw/rtl/dgp_chan.sv
// One color channel: scale product (stage 3) and dithered byte result (stage 4).
module dgp_chan (
    input  logic                               i_clk,
    input  dgp_pkg::t_pipe_en                  i_en,
    input  logic signed [dgp_pkg::GRAD_W-1:0]  i_grad,
    input  logic [dgp_pkg::DITH_W-1:0]         i_dith,
    input  logic [dgp_pkg::SCALE_W-1:0]        i_scale,
    input  logic [dgp_pkg::BASE_W-1:0]         i_base,
    input  logic                               i_force,
    output logic [dgp_pkg::BASE_W-1:0]         o_byte
);
    import dgp_pkg::*;

    // Only the low bits of the product reach the output byte, so the
    // product is kept modulo two to the power of the scale width.
    logic [SCALE_W-1:0] grad_ext;
    logic [SCALE_W-1:0] n_prod;
    logic [SCALE_W-1:0] r_prod;
    logic [DITH_W-1:0]  r_dith;
    logic [SCALE_W-1:0] sum;
    logic [BASE_W-1:0]  n_byte;
    logic [BASE_W-1:0]  r_byte;

    always_comb begin
        grad_ext = SCALE_W'(i_grad);
        n_prod   = i_scale * grad_ext;
        sum      = r_prod + SCALE_W'({r_dith, {DITH_SHIFT{1'b0}}});
        n_byte   = i_force ? OPAQUE_BYTE : i_base + sum[FRAC_BITS+BASE_W-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_prod <= n_prod;
            r_dith <= i_dith;
        end
        if (i_en.s4) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

### hw/rtl/dithered_gradient_pixel.sv
// Top level of the dithered linear gradient pixel source.
// Each accepted coordinate beat yields one four-byte pixel beat. While the output is not
// stalled a new coordinate is taken in every cycle, so the sustained rate is one pixel per
// clock. The four pipeline stages are the coordinate clamp with the two weight
// products and the Bayer lookup, the gradient sum, the per-channel scale multiply, and the
// dither add with the base color into the output register. Each stage holds its beat while
// the stage after it is full and stalled, and bubbles close up. Coordinates above MAX_DIM are
// clamped to it. Configuration is written over APB at byte address 8 times the register index
// and must only change while no beat is in flight.
module dithered_gradient_pixel #(
    parameter int unsigned MAX_DIM = dgp_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dgp_pos_if.sink                     i_pos,
    dgp_pix_if.source                   o_pix,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dgp_pkg::APB_AW-1:0]  paddr,
    input  logic [dgp_pkg::APB_DW-1:0]  pwdata,
    output logic [dgp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import dgp_pkg::*;

    t_cfg                      cfg;
    t_pipe_en                  en;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r_v4;
    logic                      rdy1;
    logic                      rdy2;
    logic                      rdy3;
    logic                      rdy4;
    logic signed [GRAD_W-1:0]  grad;
    logic [DITH_W-1:0]         dith;
    logic [CHAN_N-1:0][BASE_W-1:0] bytes;
    logic [CHAN_N-1:0]         force_opaque;

    dgp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        rdy4  = !r_v4 || o_pix.ready;
        rdy3  = !r_v3 || rdy4;
        rdy2  = !r_v2 || rdy3;
        rdy1  = !r_v1 || rdy2;
        en.s1 = rdy1;
        en.s2 = rdy2;
        en.s3 = rdy3;
        en.s4 = rdy4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_pos.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    dgp_grad #(
        .MAX_DIM (MAX_DIM)
    ) u_grad (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_pos_x (i_pos.pos_x),
        .i_pos_y (i_pos.pos_y),
        .o_grad  (grad),
        .o_dith  (dith)
    );

    assign force_opaque = {!cfg.alpha_mode, {(CHAN_N-1){1'b0}}};

    for (genvar c = 0; c < CHAN_N; c++) begin : g_chan
        dgp_chan u_chan (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_grad  (grad),
            .i_dith  (dith),
            .i_scale (cfg.scale[c]),
            .i_base  (cfg.base[c]),
            .i_force (force_opaque[c]),
            .o_byte  (bytes[c])
        );
    end

    assign i_pos.ready = rdy1;
    assign o_pix.valid = r_v4;
    assign o_pix.byte0 = bytes[0];
    assign o_pix.byte1 = bytes[1];
    assign o_pix.byte2 = bytes[2];
    assign o_pix.byte3 = bytes[3];

endmodule

### dv/dithered_gradient_pixel_tb.sv
// Self-checking testbench for the dithered gradient pixel source, with a predictor and random stalls.
`timescale 1ns / 1ps

module dithered_gradient_pixel_tb;
    import dgp_pkg::*;

    localparam int unsigned DIM_LIMIT   = MAX_DIM_DEF;
    localparam int          PHASES      = 10;
    localparam int          PHASE_BEATS = 193;
    localparam int          STALL_LIMIT = 500;

    typedef logic [CHAN_N-1:0][BASE_W-1:0] t_pixel;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_coord;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    dgp_pos_if pos_bus();
    dgp_pix_if pix_bus();

    dithered_gradient_pixel dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pos   (pos_bus),
        .o_pix   (pix_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg        shadow_cfg;
    t_coord      coords_to_send[$];
    t_pixel      pixels_due[$];
    int unsigned mismatches;
    bit          calm;
    int unsigned send_gap;
    int unsigned sink_gap;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic t_pixel gradient_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [DITH_W-1:0] bayer;
        longint            grad;
        longint            sum;
        t_pixel            pix;
        x = (px > DIM_LIMIT) ? POS_W'(DIM_LIMIT) : px;
        y = (py > DIM_LIMIT) ? POS_W'(DIM_LIMIT) : py;
        // The Bayer value interleaves the low three bits of x xor y and of y, bit zero in the most significant place.
        bayer = {x[0] ^ y[0], y[0], x[1] ^ y[1], y[1], x[2] ^ y[2], y[2]};
        grad = longint'(x) * longint'($signed(shadow_cfg.step_x))
             + longint'(y) * longint'($signed(shadow_cfg.step_y))
             - longint'($signed(shadow_cfg.grad_floor));
        for (int k = 0; k < CHAN_N; k++) begin
            sum = longint'(shadow_cfg.scale[k]) * grad + (longint'(bayer) <<< DITH_SHIFT);
            sum = longint'(shadow_cfg.base[k]) + (sum >>> FRAC_BITS);
            pix[k] = sum[7:0];
        end
        if (!shadow_cfg.alpha_mode) begin
            pix[3] = OPAQUE_BYTE;
        end
        return pix;
    endfunction

    function automatic logic [POS_W-1:0] draw_pos();
        case ($urandom_range(0, 9))
            0: return POS_W'($urandom_range(DIM_LIMIT + 1, POS_TOP));
            1: return POS_W'($urandom_range(0, 15));
            default: return POS_W'($urandom_range(0, DIM_LIMIT));
        endcase
    endfunction

    function automatic t_cfg draw_cfg(bit wide);
        t_cfg c;
        c.step_x     = wide ? STEP_W'($urandom) : STEP_W'($urandom_range(0, 128) - 64);
        c.step_y     = wide ? STEP_W'($urandom) : STEP_W'($urandom_range(0, 128) - 64);
        c.grad_floor = wide ? FLOOR_W'($urandom)
                            : FLOOR_W'($urandom_range(0, 1 << 20) - (1 << 19));
        c.alpha_mode = 1'($urandom_range(0, 1));
        for (int k = 0; k < CHAN_N; k++) begin
            c.base[k] = BASE_W'($urandom);
            case ($urandom_range(0, 3))
                0: c.scale[k] = SCALE_W'($urandom_range(0, 1 << 16));
                1: c.scale[k] = SCALE_W'($urandom_range(0, 1 << 24));
                2: c.scale[k] = SCALE_W'($urandom);
                default: c.scale[k] = $urandom_range(0, 1) ? '1 : '0;
            endcase
        end
        return c;
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_STEP_X: shadow_cfg.step_x     = data[STEP_W-1:0];
            REG_STEP_Y: shadow_cfg.step_y     = data[STEP_W-1:0];
            REG_FLOOR:  shadow_cfg.grad_floor = data[FLOOR_W-1:0];
            REG_ALPHA:  shadow_cfg.alpha_mode = data[0];
            default: begin
                shadow_cfg.base[idx - REG_CHAN0]  = data[BASE_W-1:0];
                shadow_cfg.scale[idx - REG_CHAN0] = data[WORD_W-1:BASE_W];
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Every register is written with random junk above its width.
    task automatic load_cfg(t_cfg c);
        logic [APB_DW-1:0] w;
        w = {$urandom, $urandom};
        w[STEP_W-1:0] = c.step_x;
        apb_write(REG_STEP_X, w);
        w = {$urandom, $urandom};
        w[STEP_W-1:0] = c.step_y;
        apb_write(REG_STEP_Y, w);
        w = {$urandom, $urandom};
        w[FLOOR_W-1:0] = c.grad_floor;
        apb_write(REG_FLOOR, w);
        w = {$urandom, $urandom};
        w[0] = c.alpha_mode;
        apb_write(REG_ALPHA, w);
        for (int k = 0; k < CHAN_N; k++) begin
            w = {$urandom, $urandom};
            w[WORD_W-1:0] = {c.scale[k], c.base[k]};
            apb_write(t_reg_idx'(REG_CHAN0 + k), w);
        end
        @(negedge i_clk);
    endtask

    task automatic queue_coord(int unsigned x, int unsigned y);
        coords_to_send.push_back('{x: POS_W'(x), y: POS_W'(y)});
    endtask

    // About half of the groups are short raster runs along a row, some crossing the clamp edge.
    task automatic queue_phase(int count);
        int               left;
        int               run;
        int unsigned      x0;
        logic [POS_W-1:0] y;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 1)) begin
                run = $urandom_range(4, 24);
                if (run > left) begin
                    run = left;
                end
                x0 = $urandom_range(0, DIM_LIMIT + 8);
                y  = draw_pos();
                for (int j = 0; j < run; j++) begin
                    queue_coord(x0 + j, y);
                end
                left -= run;
            end else begin
                queue_coord(draw_pos(), draw_pos());
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (coords_to_send.size() != 0 || pos_bus.valid || pixels_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_coord c;
        if (!i_rst_n) begin
            pos_bus.valid <= 1'b0;
            send_gap      <= 0;
        end else if (!pos_bus.valid || pos_bus.ready) begin
            if (send_gap != 0) begin
                pos_bus.valid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (!calm && $urandom_range(0, 19) == 0) begin
                pos_bus.valid <= 1'b0;
                send_gap      <= $urandom_range(0, 15);
            end else if (coords_to_send.size() != 0) begin
                c = coords_to_send.pop_front();
                pos_bus.valid <= 1'b1;
                pos_bus.pos_x <= c.x;
                pos_bus.pos_y <= c.y;
            end else begin
                pos_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.ready <= 1'b0;
            sink_gap      <= 0;
        end else if (sink_gap != 0) begin
            pix_bus.ready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            pix_bus.ready <= 1'b0;
            sink_gap      <= $urandom_range(0, 15);
        end else begin
            pix_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (i_rst_n) begin
            if (pos_bus.valid && pos_bus.ready) begin
                pixels_due.push_back(gradient_pixel(pos_bus.pos_x, pos_bus.pos_y));
            end
            if (pix_bus.valid && pix_bus.ready) begin
                got = {pix_bus.byte3, pix_bus.byte2, pix_bus.byte1, pix_bus.byte0};
                if (pixels_due.size() == 0) begin
                    report("pixel beat with nothing pending, byte0", got[0], -1);
                end else begin
                    want = pixels_due.pop_front();
                    for (int k = 0; k < CHAN_N; k++) begin
                        if (got[k] !== want[k]) begin
                            report($sformatf("byte%0d", k), got[k], want[k]);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pos_bus.valid && pos_bus.ready) || (pix_bus.valid && pix_bus.ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cfg c;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pos_bus.valid = 1'b0;
        pos_bus.pos_x = '0;
        pos_bus.pos_y = '0;
        pix_bus.ready = 1'b0;
        calm          = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        shadow_cfg    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers at their reset values.
        queue_coord(0, 0);
        queue_coord(4096, 4096);
        queue_coord(13, 6);
        queue_coord(8191, 1);
        wait_drained();

        // Largest positive gradient with full-scale channels zero and one, alpha from channel three.
        c            = '0;
        c.step_x     = 8'sd127;
        c.step_y     = 8'sd127;
        c.grad_floor = 21'h100000;
        c.alpha_mode = 1'b1;
        c.base       = {8'h01, 8'h80, 8'h00, 8'hFF};
        c.scale[0]   = '1;
        c.scale[1]   = '1;
        c.scale[2]   = 31'd1;
        c.scale[3]   = '0;
        load_cfg(c);
        queue_coord(0, 0);
        queue_coord(4096, 4096);
        queue_coord(4097, 4097);
        queue_coord(8191, 8191);
        queue_coord(4096, 0);
        queue_coord(0, 8191);
        queue_coord(1, 2);
        queue_coord(7, 7);
        wait_drained();

        // Most negative gradient, so the channel sums round toward minus infinity.
        c            = '0;
        c.step_x     = -8'sd128;
        c.step_y     = -8'sd128;
        c.grad_floor = 21'h0FFFFF;
        c.alpha_mode = 1'b1;
        c.scale[0]   = '1;
        c.scale[1]   = 31'd3;
        c.scale[2]   = 31'd1 << 20;
        c.scale[3]   = '1;
        load_cfg(c);
        queue_coord(4096, 4096);
        queue_coord(8191, 0);
        queue_coord(3, 5);
        queue_coord(6, 4);
        queue_coord(1, 1);
        wait_drained();

        // Opaque mode with a typical ramp.
        c            = '0;
        c.step_x     = 8'sd64;
        c.step_y     = -8'sd64;
        c.grad_floor = -21'sd524288;
        c.alpha_mode = 1'b0;
        c.base       = {8'h55, 8'h10, 8'h20, 8'h30};
        c.scale      = {31'd9000, 31'd16384, 31'd2048, 31'd700};
        load_cfg(c);
        queue_coord(100, 200);
        queue_coord(2, 3);
        queue_coord(4096, 1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            load_cfg(draw_cfg(p % 3 == 2));
            calm = (p == PHASES - 1);
            queue_phase(PHASE_BEATS);
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
